### sv/hpr_pkg.sv
`default_nettype none
package hpr_pkg;

  // command codes carried in the kind field
  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_RAMP_UP   = 3'd1,
    CMD_RAMP_DOWN = 3'd2,
    CMD_STOP      = 3'd3,
    CMD_REVERSE   = 3'd4
  } cmd_kind_t;

  // configuration register indexes
  localparam logic [1:0] REG_TARGET_DUTY = 2'd0;
  localparam logic [1:0] REG_DUTY_STEP   = 2'd1;
  localparam logic [1:0] REG_START_DUTY  = 2'd2;

  // configuration reset values
  localparam int TARGET_DUTY_RESET = 255;
  localparam int DUTY_STEP_RESET   = 5;
  localparam int START_DUTY_RESET  = 10;

  // control flags of the sequencer
  typedef struct packed {
    logic running;
    logic up_busy;
    logic up_swap;
    logic down_busy;
    logic down_swap;
    logic swap;
  } seq_flags_t;

endpackage
`default_nettype wire

### sv/hbridge_pwm_ramp_sequencer_core.sv
`default_nettype none
// Soft-start sequencer for a two-input H-bridge. Each command word (tick, ramp up,
// ramp down, abrupt stop, reverse) is decoded and applied to the ramp state in the
// cycle it is accepted, and exactly one result word with both pin duties and the
// status bits comes out, in order, through the output buffer. One command is taken
// every cycle while in_stall is low; results queue in a two-word output buffer,
// and in_stall rises only while both words of that buffer are held. Configuration
// writes take effect at the next edge and belong to idle periods.
module hbridge_pwm_ramp_sequencer_core #(
  parameter int DUTY_BITS = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [DUTY_BITS-1:0] cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [2:0]           kind,
  input  wire logic                 swap_when_done,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [DUTY_BITS-1:0]      pin_a_level,
  output logic [DUTY_BITS-1:0]      pin_b_level,
  output logic                      is_running,
  output logic                      up_ramp_active,
  output logic                      down_ramp_active,
  output logic                      pins_swapped
);
  import hpr_pkg::*;

  localparam int LW = DUTY_BITS + 2;
  localparam int WORD_W = 2 * DUTY_BITS + 4;

  logic [DUTY_BITS-1:0] target_duty;
  logic [DUTY_BITS-1:0] duty_step;
  logic [DUTY_BITS-1:0] start_duty;

  seq_flags_t           flags;
  seq_flags_t           flags_next;
  logic [LW-1:0]        up_level;
  logic [LW-1:0]        up_level_next;
  logic [LW-1:0]        down_level;
  logic [LW-1:0]        down_level_next;
  logic [DUTY_BITS-1:0] level_a;
  logic [DUTY_BITS-1:0] level_a_next;
  logic [DUTY_BITS-1:0] level_b;
  logic [DUTY_BITS-1:0] level_b_next;

  logic                 accept;
  logic                 buf_full;
  logic [WORD_W-1:0]    result_word;
  logic [WORD_W-1:0]    out_word;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_duty <= DUTY_BITS'(TARGET_DUTY_RESET);
      duty_step   <= DUTY_BITS'(DUTY_STEP_RESET);
      start_duty  <= DUTY_BITS'(START_DUTY_RESET);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TARGET_DUTY: target_duty <= cfg_data;
        REG_DUTY_STEP:   duty_step   <= cfg_data;
        REG_START_DUTY:  start_duty  <= cfg_data;
        default: begin
          // no register at this index
        end
      endcase
    end
  end

  // command decode and next state
  hpr_step #(
    .DUTY_BITS(DUTY_BITS)
  ) u_step (
    .kind            (kind),
    .swap_when_done  (swap_when_done),
    .target_duty     (target_duty),
    .duty_step       (duty_step),
    .start_duty      (start_duty),
    .flags           (flags),
    .up_level        (up_level),
    .down_level      (down_level),
    .level_a         (level_a),
    .level_b         (level_b),
    .flags_next      (flags_next),
    .up_level_next   (up_level_next),
    .down_level_next (down_level_next),
    .level_a_next    (level_a_next),
    .level_b_next    (level_b_next)
  );

  // sequencer state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      flags      <= '0;
      up_level   <= '0;
      down_level <= '0;
      level_a    <= '0;
      level_b    <= '0;
    end else if (accept) begin
      flags      <= flags_next;
      up_level   <= up_level_next;
      down_level <= down_level_next;
      level_a    <= level_a_next;
      level_b    <= level_b_next;
    end
  end

  // result word from the updated state
  assign result_word = {level_a_next, level_b_next, flags_next.running,
                        flags_next.up_busy, flags_next.down_busy, flags_next.swap};

  hpr_obuf #(
    .WIDTH(WORD_W)
  ) u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_word (result_word),
    .full      (buf_full),
    .pop_valid (out_valid),
    .pop_stall (out_stall),
    .pop_word  (out_word)
  );

  // unpack the result word
  assign pin_a_level      = out_word[WORD_W-1 -: DUTY_BITS];
  assign pin_b_level      = out_word[DUTY_BITS+3 -: DUTY_BITS];
  assign is_running       = out_word[3];
  assign up_ramp_active   = out_word[2];
  assign down_ramp_active = out_word[1];
  assign pins_swapped     = out_word[0];

endmodule
`default_nettype wire

### sv/hpr_step.sv
`default_nettype none
module hpr_step #(
  parameter int DUTY_BITS = 10
) (
  input  wire logic [2:0]             kind,
  input  wire logic                   swap_when_done,
  input  wire logic [DUTY_BITS-1:0]   target_duty,
  input  wire logic [DUTY_BITS-1:0]   duty_step,
  input  wire logic [DUTY_BITS-1:0]   start_duty,
  input  wire hpr_pkg::seq_flags_t    flags,
  input  wire logic [DUTY_BITS+1:0]   up_level,
  input  wire logic [DUTY_BITS+1:0]   down_level,
  input  wire logic [DUTY_BITS-1:0]   level_a,
  input  wire logic [DUTY_BITS-1:0]   level_b,
  output hpr_pkg::seq_flags_t         flags_next,
  output logic [DUTY_BITS+1:0]        up_level_next,
  output logic [DUTY_BITS+1:0]        down_level_next,
  output logic [DUTY_BITS-1:0]        level_a_next,
  output logic [DUTY_BITS-1:0]        level_b_next
);
  import hpr_pkg::*;

  localparam int LW = DUTY_BITS + 2;

  logic [LW-1:0] up_sum;
  logic          up_done;
  logic          down_done;
  logic          up_go;
  logic          swap_mid;

  // up-ramp step and finish test
  assign up_sum  = up_level + LW'(duty_step);
  assign up_done = up_sum > LW'(target_duty);
  assign up_go   = flags.up_busy && !flags.running;

  // pin roles after a possible up-ramp finish on this tick
  assign swap_mid  = flags.swap ^ (up_go && up_done && flags.up_swap);
  assign down_done = down_level < LW'(duty_step);

  // command decode and state update
  always_comb begin
    flags_next      = flags;
    up_level_next   = up_level;
    down_level_next = down_level;
    level_a_next    = level_a;
    level_b_next    = level_b;
    unique case (cmd_kind_t'(kind))
      CMD_TICK: begin
        // up-ramp runs first, only while stopped
        if (up_go) begin
          up_level_next = up_sum;
          if (up_done) begin
            flags_next.up_busy = 1'b0;
            flags_next.swap    = swap_mid;
            flags_next.running = 1'b1;
            if (swap_mid) begin
              level_a_next = target_duty;
              if (!flags.swap) begin
                level_b_next = up_level[DUTY_BITS-1:0];
              end
            end else begin
              level_b_next = target_duty;
              if (flags.swap) begin
                level_a_next = up_level[DUTY_BITS-1:0];
              end
            end
          end else if (flags.swap) begin
            level_a_next = up_level[DUTY_BITS-1:0];
          end else begin
            level_b_next = up_level[DUTY_BITS-1:0];
          end
        end
        // down-ramp sees what the up-ramp left
        if (flags.down_busy && flags_next.running) begin
          if (down_done) begin
            if (swap_mid) begin
              level_a_next = '0;
            end else begin
              level_b_next = '0;
            end
            flags_next.down_busy = 1'b0;
            flags_next.swap      = swap_mid ^ flags.down_swap;
            flags_next.running   = 1'b0;
          end else begin
            if (swap_mid) begin
              level_a_next = down_level[DUTY_BITS-1:0];
            end else begin
              level_b_next = down_level[DUTY_BITS-1:0];
            end
            down_level_next = down_level - LW'(duty_step);
          end
        end
      end
      CMD_RAMP_UP: begin
        up_level_next      = LW'(start_duty);
        flags_next.up_swap = swap_when_done;
        flags_next.up_busy = 1'b1;
        if (flags.swap) begin
          level_b_next = '0;
        end else begin
          level_a_next = '0;
        end
      end
      CMD_RAMP_DOWN: begin
        down_level_next      = LW'(target_duty);
        flags_next.down_swap = swap_when_done;
        flags_next.down_busy = 1'b1;
        if (flags.swap) begin
          level_b_next = '0;
        end else begin
          level_a_next = '0;
        end
      end
      CMD_STOP: begin
        flags_next.up_busy   = 1'b0;
        flags_next.down_busy = 1'b0;
        flags_next.running   = 1'b0;
        if (flags.swap) begin
          level_a_next = '0;
        end else begin
          level_b_next = '0;
        end
      end
      CMD_REVERSE: begin
        // running: ramp down with swap, then ramp up without swap; stopped: ramp up with swap
        up_level_next      = LW'(start_duty);
        flags_next.up_busy = 1'b1;
        flags_next.up_swap = !flags.running;
        if (flags.running) begin
          down_level_next      = LW'(target_duty);
          flags_next.down_swap = 1'b1;
          flags_next.down_busy = 1'b1;
        end
        if (flags.swap) begin
          level_b_next = '0;
        end else begin
          level_a_next = '0;
        end
      end
      default: begin
        // unused codes leave the state alone
      end
    endcase
  end

endmodule
`default_nettype wire

### sv/hpr_obuf.sv
`default_nettype none
module hpr_obuf #(
  parameter int WIDTH = 24
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_word,
  output logic                  full,
  output logic                  pop_valid,
  input  wire logic             pop_stall,
  output logic [WIDTH-1:0]      pop_word
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             pop;

  assign full      = count == 2'd2;
  assign pop_valid = count != 2'd0;
  assign pop       = pop_valid && !pop_stall;
  assign pop_word  = entry[rd_ptr];

  // two-word queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_word;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire
